### design/voc_block_parser_unit_defines.svh
// assertion macros for the voice block parser
// used by the files that carry concurrent checks
`ifndef VOC_BLOCK_PARSER_UNIT_DEFINES_SVH
`define VOC_BLOCK_PARSER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define VBP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define VBP_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define VBP_ASSERT(label, clk, rst, prop)
`define VBP_ASSERT_RST(label, clk, prop)
`endif
`endif

### design/vbp_pkg.sv
// shared types and constants for the voice block parser
// no dependencies
package vbp_pkg;
   localparam int ADDR_BITS = 32;
   localparam int QDEPTH = 2;

   localparam logic [1:0] ACT_ADVANCE = 2'd0;
   localparam logic [1:0] ACT_VOICE   = 2'd1;
   localparam logic [1:0] ACT_TERM    = 2'd2;

   localparam logic [7:0] BT_END    = 8'd0;
   localparam logic [7:0] BT_VOICE  = 8'd1;
   localparam logic [7:0] BT_MARKER = 8'd4;
   localparam logic [7:0] BT_REPEAT = 8'd6;
   localparam logic [7:0] BT_ENDREP = 8'd7;
   localparam logic [7:0] BT_EXTATTR = 8'd8;
   localparam logic [7:0] BT_EXTVOICE = 8'd9;

   localparam logic [0:0] CSR_PLAY_ALL = 1'd0;
   localparam logic [0:0] CSR_TARGET   = 1'd1;

   localparam logic [31:0] RATE_VOICE  = 32'd1000000;
   localparam logic [31:0] RATE_MONO   = 32'd256000000;
   localparam logic [31:0] RATE_STEREO = 32'd128000000;
   localparam logic [16:0] PERIOD_EXT  = 17'd65536;
   localparam logic [8:0]  PERIOD_VOICE = 9'd256;
   localparam logic [15:0] LOOP_ENDLESS = 16'hffff;

   // classified item passed from front to back
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] next_addr;
      logic [31:0] sample_addr;
      logic [23:0] sample_len;
      logic [31:0] rate;          // direct rate or dividend
      logic [16:0] divisor;
      logic        need_div;
      logic [2:0]  sample_kind;
      logic        start_now;
   } item_type;
endpackage

### design/vbp_front.sv
// front end: accepts block headers, keeps loop and marker state, classifies
// depends on vbp_pkg
module vbp_front import vbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_block_addr,
   input  logic [7:0]  req_block_type,
   input  logic [23:0] req_body_len,
   input  logic [15:0] req_tconst,
   input  logic [7:0]  req_attr_mode,
   input  logic signed [15:0] req_marker_value,
   input  logic [15:0] req_loop_count,
   input  logic [31:0] req_ext_sample_rate,
   input  logic [7:0]  req_ext_channels,
   input  logic [15:0] req_ext_format,
   input  logic [23:0] req_paired_len,
   input  logic        req_start_play,
   output logic        q_valid,
   input  logic        q_ready,
   output item_type    q_item
);
   logic        play_all_ff, play_all_in;
   logic [15:0] target_ff, target_in;
   logic        found_ff, found_in;
   logic [ADDR_BITS-1:0] ret_ff, ret_in;
   logic [15:0] left_ff, left_in;
   logic        fin_ff, fin_in;
   item_type    it;
   logic        acc;
   logic [ADDR_BITS-1:0] a, nxt, paddr;

   assign req_ready = q_ready;
   assign q_valid = req_valid;
   assign q_item = it;
   assign acc = req_valid && q_ready;

   function automatic logic [ADDR_BITS-1:0] after(input logic [ADDR_BITS-1:0] ad,
                                                  input logic [23:0] ln);
      after = ad + ADDR_BITS'(ln) + ADDR_BITS'(4);
   endfunction

   always_comb begin
      a = req_block_addr[ADDR_BITS-1:0];
      nxt = after(a, req_body_len);
      paddr = nxt;
      play_all_in = play_all_ff;
      target_in = target_ff;
      found_in = found_ff;
      ret_in = ret_ff;
      left_in = left_ff;
      fin_in = fin_ff;
      it = '0;
      it.action = ACT_ADVANCE;
      it.next_addr = 32'(nxt);
      if (fin_ff) begin
         it.action = ACT_TERM;
         it.next_addr = 32'(a);
      end else begin
         case (req_block_type)
            BT_END: begin
               it.action = ACT_TERM;
               it.next_addr = 32'(a);
               fin_in = 1'b1;
            end
            BT_VOICE: if (found_ff) begin
               it.action = ACT_VOICE;
               it.sample_addr = 32'(a + ADDR_BITS'(6));
               it.sample_len = (req_body_len > 24'd2) ? req_body_len - 24'd2 : '0;
               it.rate = RATE_VOICE;
               it.divisor = 17'(PERIOD_VOICE - {1'b0, req_tconst[7:0]});
               it.need_div = 1'b1;
               it.sample_kind = 3'd1;
               it.start_now = req_start_play;
            end
            BT_MARKER: if (!play_all_ff)
               found_in = (req_marker_value == $signed(target_ff));
            BT_REPEAT: begin
               ret_in = nxt;
               left_in = req_loop_count;
            end
            BT_ENDREP: begin
               if (left_ff == LOOP_ENDLESS) begin
                  it.next_addr = 32'(ret_ff);
               end else if (left_ff != '0) begin
                  left_in = left_ff - 16'd1;
                  it.next_addr = 32'(ret_ff);
               end
            end
            BT_EXTATTR: if (found_ff) begin
               it.action = ACT_VOICE;
               it.rate = (req_attr_mode != '0) ? RATE_STEREO : RATE_MONO;
               it.sample_kind = (req_attr_mode != '0) ? 3'd2 : 3'd1;
               it.divisor = PERIOD_EXT - {1'b0, req_tconst};
               it.need_div = 1'b1;
               it.sample_addr = 32'(paddr + ADDR_BITS'(6));
               it.sample_len = (req_paired_len > 24'd2) ? req_paired_len - 24'd2 : '0;
               it.next_addr = 32'(after(paddr, req_paired_len));
               it.start_now = req_start_play;
            end
            BT_EXTVOICE: if (found_ff) begin
               it.action = ACT_VOICE;
               it.sample_addr = 32'(a + ADDR_BITS'(16));
               it.sample_len = (req_body_len > 24'd12) ? req_body_len - 24'd12 : '0;
               it.rate = req_ext_sample_rate;
               if (req_ext_channels == 8'd1 && req_ext_format == 16'd0) it.sample_kind = 3'd1;
               else if (req_ext_channels == 8'd2 && req_ext_format == 16'd0)
                  it.sample_kind = 3'd2;
               else if (req_ext_channels == 8'd1 && req_ext_format == 16'd4)
                  it.sample_kind = 3'd3;
               else if (req_ext_channels == 8'd2 && req_ext_format == 16'd4)
                  it.sample_kind = 3'd4;
               it.start_now = req_start_play;
            end
            default: ;
         endcase
      end
      if (!acc) begin
         found_in = found_ff; ret_in = ret_ff; left_in = left_ff; fin_in = fin_ff;
      end
      if (csr_write) begin
         case (csr_index)
            CSR_PLAY_ALL: begin
               play_all_in = csr_data[0];
               found_in = csr_data[0];
            end
            CSR_TARGET: target_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         play_all_ff <= 1'b1;
         target_ff <= '0;
         found_ff <= 1'b1;
         ret_ff <= '0;
         left_ff <= '0;
         fin_ff <= 1'b0;
      end else begin
         play_all_ff <= play_all_in;
         target_ff <= target_in;
         found_ff <= found_in;
         ret_ff <= ret_in;
         left_ff <= left_in;
         fin_ff <= fin_in;
      end
   end
endmodule

### design/vbp_queue.sv
// short fifo of classified items between front and back
// depends on vbp_pkg
`include "voc_block_parser_unit_defines.svh"
module vbp_queue import vbp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);
   item_type mem_ff [QDEPTH];
   logic [$clog2(QDEPTH)-1:0] wp_ff, rp_ff;
   logic [$clog2(QDEPTH):0] cnt_ff;
   logic wr, rd;

   assign in_ready = cnt_ff != ($clog2(QDEPTH)+1)'(QDEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_item = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= in_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 1'b1;
         if (rd) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + ($clog2(QDEPTH)+1)'(wr) - ($clog2(QDEPTH)+1)'(rd);
      end
   end

   `VBP_ASSERT(q_no_overflow, clock, reset, cnt_ff <= ($clog2(QDEPTH)+1)'(QDEPTH))
   `VBP_ASSERT(q_count_step, clock, reset, (wr && !rd) |=> cnt_ff == $past(cnt_ff) + 1'b1)
   `VBP_ASSERT_RST(q_reset_empty, clock, $past(reset) |-> cnt_ff == '0)
endmodule

### design/vbp_back.sv
// back end: divides the rate where needed and holds the result beat
// depends on vbp_pkg
`include "voc_block_parser_unit_defines.svh"
module vbp_back import vbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  item_type    q_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [31:0] rsp_next_addr,
   output logic [31:0] rsp_sample_addr,
   output logic [23:0] rsp_sample_len,
   output logic [31:0] rsp_playback_rate,
   output logic [2:0]  rsp_sample_kind,
   output logic        rsp_start_now
);
   typedef enum logic [1:0] {IDLE, DIVIDE, HOLD} state_type;
   state_type   state_ff;
   item_type    cur_ff;
   logic [31:0] quo_ff;
   logic [16:0] rem_ff;
   logic [5:0]  cnt_ff;
   logic [17:0] trial;

   assign q_ready = state_ff == IDLE;
   assign rsp_valid = state_ff == HOLD;
   assign rsp_action = cur_ff.action;
   assign rsp_next_addr = cur_ff.next_addr;
   assign rsp_sample_addr = cur_ff.sample_addr;
   assign rsp_sample_len = cur_ff.sample_len;
   assign rsp_playback_rate = cur_ff.rate;
   assign rsp_sample_kind = cur_ff.sample_kind;
   assign rsp_start_now = cur_ff.start_now;
   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, cur_ff.divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff <= '0;
      end else begin
         case (state_ff)
            IDLE: if (q_valid) begin
               cur_ff <= q_item;
               quo_ff <= q_item.rate;
               rem_ff <= '0;
               cnt_ff <= '0;
               state_ff <= q_item.need_div ? DIVIDE : HOLD;
            end
            DIVIDE: begin
               if (!trial[17]) begin
                  rem_ff <= trial[16:0];
                  quo_ff <= {quo_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[15:0], quo_ff[31]};
                  quo_ff <= {quo_ff[30:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  state_ff <= HOLD;
                  cur_ff.rate <= {quo_ff[30:0], ~trial[17]};
               end
            end
            HOLD: if (rsp_ready) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   `VBP_ASSERT(b_div_only_voice, clock, reset,
      (state_ff == DIVIDE) |-> cur_ff.action == ACT_VOICE)
   `VBP_ASSERT(b_hold_stable, clock, reset,
      (rsp_valid && !rsp_ready) |=> $stable(cur_ff))
   `VBP_ASSERT(b_div_count, clock, reset,
      (state_ff == DIVIDE && cnt_ff == 6'd31) |=> state_ff == HOLD)
endmodule

### design/voc_block_parser_unit.sv
// voice block parser top level: block headers in, one action beat out each
// front classifies, a two-entry queue decouples it from the back end.
// req channel: one decoded block header per beat, valid/ready.
// rsp channel: one action beat per header, in order, valid/ready.
// csr port: write enable, index 0 play_all, index 1 target_marker.
// plain items pass through the queue register and the back end's IDLE
// state to HOLD, where rsp_valid rises; voice and extended attribute
// blocks also pass through the bit-serial rate divider before HOLD.
// the back end takes a new item only in IDLE, once the last result beat
// is taken; its single divider holds off the next item while it divides.
// the front keeps accepting while the queue has room, so header state
// updates run ahead of the divider.
// reset is synchronous: loop state and finished clear, markers pass, and
// play_all returns to 1.
// when the receiver stalls the result beat holds, the queue fills and
// then req_ready drops.
// depends on vbp_pkg and the front, queue and back modules
module voc_block_parser_unit import vbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_block_addr,
   input  logic [7:0]  req_block_type,
   input  logic [23:0] req_body_len,
   input  logic [15:0] req_tconst,
   input  logic [7:0]  req_attr_mode,
   input  logic signed [15:0] req_marker_value,
   input  logic [15:0] req_loop_count,
   input  logic [31:0] req_ext_sample_rate,
   input  logic [7:0]  req_ext_channels,
   input  logic [15:0] req_ext_format,
   input  logic [23:0] req_paired_len,
   input  logic        req_start_play,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [31:0] rsp_next_addr,
   output logic [31:0] rsp_sample_addr,
   output logic [23:0] rsp_sample_len,
   output logic [31:0] rsp_playback_rate,
   output logic [2:0]  rsp_sample_kind,
   output logic        rsp_start_now
);
   logic fq_valid, fq_ready, qb_valid, qb_ready;
   item_type fq_item, qb_item;

   vbp_front u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_valid, .req_ready, .req_block_addr, .req_block_type, .req_body_len,
      .req_tconst, .req_attr_mode, .req_marker_value, .req_loop_count,
      .req_ext_sample_rate, .req_ext_channels, .req_ext_format, .req_paired_len,
      .req_start_play,
      .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
   );

   vbp_queue u_queue (
      .clock, .reset,
      .in_valid(fq_valid), .in_ready(fq_ready), .in_item(fq_item),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_item(qb_item)
   );

   vbp_back u_back (
      .clock, .reset,
      .q_valid(qb_valid), .q_ready(qb_ready), .q_item(qb_item),
      .rsp_valid, .rsp_ready, .rsp_action, .rsp_next_addr, .rsp_sample_addr,
      .rsp_sample_len, .rsp_playback_rate, .rsp_sample_kind, .rsp_start_now
   );
endmodule
